@@ rtl/core/sdfc_pkg.sv @@
package sdfc_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HEADER   = 3'd1,
        ST_COMMAND  = 3'd2,
        ST_END      = 3'd3,
        ST_CHECKSUM = 3'd4,
        ST_LENGTH   = 3'd5
    } t_status;

    // Frame layout
    localparam int unsigned POS_W       = 10;
    localparam int unsigned SINGLE_LEN  = 267;
    localparam int unsigned BANK_LEN    = 524;
    localparam int unsigned PAY_START   = 9;
    localparam int unsigned HDR_LEN     = 5;

    // Positions of the last summed byte, checksum byte and end byte;
    // every byte from PAY_START up to the one before the checksum is summed
    localparam logic [POS_W-1:0] PAY_LAST_SINGLE = POS_W'(SINGLE_LEN - 3);
    localparam logic [POS_W-1:0] PAY_LAST_BANK   = POS_W'(BANK_LEN - 3);
    localparam logic [POS_W-1:0] CKS_POS_SINGLE  = POS_W'(SINGLE_LEN - 2);
    localparam logic [POS_W-1:0] CKS_POS_BANK    = POS_W'(BANK_LEN - 2);
    localparam logic [POS_W-1:0] END_POS_SINGLE  = POS_W'(SINGLE_LEN - 1);
    localparam logic [POS_W-1:0] END_POS_BANK    = POS_W'(BANK_LEN - 1);

    localparam logic [POS_W-1:0] POS_SUM_FIRST = POS_W'(5);
    localparam logic [POS_W-1:0] POS_CMD       = POS_W'(6);
    localparam logic [POS_W-1:0] POS_BANK      = POS_W'(7);
    localparam logic [POS_W-1:0] POS_PROG      = POS_W'(8);

    localparam logic [7:0] CMD_BYTE  = 8'h10;
    localparam logic [7:0] END_BYTE  = 8'hF7;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Register map
    localparam logic REG_FRAME_MODE = 1'b0;

    // Result word handed from the checker to the output register
    typedef struct packed {
        t_status    status;
        logic [7:0] bank_number;
        logic [7:0] program_number;
        logic [7:0] block_index;
        logic       buffer_done;
        logic       buffer_ok;
    } t_result;

    // Expected header bytes
    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'hF0;
            3'd1:    val = 8'h00;
            3'd2:    val = 8'h20;
            3'd3:    val = 8'h33;
            3'd4:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/sdfc_in_if.sv @@
// Byte stream channel
interface sdfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/sdfc_out_if.sv @@
// Frame status channel
interface sdfc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] bank_number;
    logic [7:0] program_number;
    logic [7:0] block_index;
    logic       buffer_done;
    logic       buffer_ok;

    modport source (output valid, output status, output bank_number,
                    output program_number, output block_index,
                    output buffer_done, output buffer_ok, input ready);
    modport sink   (input valid, input status, input bank_number,
                    input program_number, input block_index,
                    input buffer_done, input buffer_ok, output ready);
endinterface

@@ rtl/core/sdfc_apb_regs.sv @@
module sdfc_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_frame_mode
);

    logic r_frame_mode;
    logic n_frame_mode;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == sdfc_pkg::REG_FRAME_MODE);

    // Mode register
    always_comb begin
        n_frame_mode = r_frame_mode;
        if (wr_en) begin
            n_frame_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_mode <= 1'b0;
        end else begin
            r_frame_mode <= n_frame_mode;
        end
    end

    // Read back; unused address bits ignored
    assign prdata = (paddr[2] == sdfc_pkg::REG_FRAME_MODE) ? {31'd0, r_frame_mode} : 32'd0;

    assign o_frame_mode = r_frame_mode;

endmodule

@@ rtl/core/sdfc_frame_chk.sv @@
module sdfc_frame_chk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic                i_frame_mode,
    output logic                o_res_vld,
    output sdfc_pkg::t_result   o_res
);

    localparam int unsigned PW = sdfc_pkg::POS_W;

    // Frame state
    logic [PW-1:0]      r_pos, n_pos;
    logic [6:0]         r_sum, n_sum;
    sdfc_pkg::t_status  r_ferr, n_ferr;
    logic [7:0]         r_bank, n_bank;
    logic [7:0]         r_prog, n_prog;
    logic [7:0]         r_count, n_count;
    logic               r_all_ok, n_all_ok;
    logic               r_overrun, n_overrun;

    // Working values for the current word
    logic [PW-1:0]      pay_last, cks_pos, end_pos;
    logic               frame_start;
    logic [6:0]         s_sum, f_sum;
    sdfc_pkg::t_status  s_ferr, f_ferr;
    logic [7:0]         s_bank, f_bank;
    logic [7:0]         s_prog, f_prog;
    logic               frame_end;
    sdfc_pkg::t_status  f_status;
    logic               ok_after;

    assign pay_last = i_frame_mode ? sdfc_pkg::PAY_LAST_BANK : sdfc_pkg::PAY_LAST_SINGLE;
    assign cks_pos  = i_frame_mode ? sdfc_pkg::CKS_POS_BANK  : sdfc_pkg::CKS_POS_SINGLE;
    assign end_pos  = i_frame_mode ? sdfc_pkg::END_POS_BANK  : sdfc_pkg::END_POS_SINGLE;

    // Start of frame clears the per-frame state
    assign frame_start = (r_pos == '0);
    assign s_sum  = frame_start ? 7'd0 : r_sum;
    assign s_ferr = frame_start ? sdfc_pkg::ST_OK : r_ferr;
    assign s_bank = frame_start ? 8'd0 : r_bank;
    assign s_prog = frame_start ? 8'd0 : r_prog;

    // Per-position checks and checksum accumulation
    always_comb begin
        f_sum  = s_sum;
        f_ferr = s_ferr;
        f_bank = s_bank;
        f_prog = s_prog;
        if (r_pos < PW'(sdfc_pkg::HDR_LEN)) begin
            if (i_data_byte != sdfc_pkg::hdr_byte(r_pos[2:0]) && s_ferr == sdfc_pkg::ST_OK) begin
                f_ferr = sdfc_pkg::ST_HEADER;
            end
        end else if (r_pos == sdfc_pkg::POS_SUM_FIRST) begin
            f_sum = s_sum + i_data_byte[6:0];
        end else if (r_pos == sdfc_pkg::POS_CMD) begin
            if (i_data_byte != sdfc_pkg::CMD_BYTE && s_ferr == sdfc_pkg::ST_OK) begin
                f_ferr = sdfc_pkg::ST_COMMAND;
            end
            f_sum = s_sum + sdfc_pkg::CMD_BYTE[6:0];
        end else if (r_pos == sdfc_pkg::POS_BANK) begin
            f_bank = i_data_byte;
            f_sum  = s_sum + i_data_byte[6:0];
        end else if (r_pos == sdfc_pkg::POS_PROG) begin
            f_prog = i_data_byte;
            f_sum  = s_sum + i_data_byte[6:0];
        end else if (r_pos <= pay_last) begin
            f_sum = s_sum + i_data_byte[6:0];
        end else if (r_pos == cks_pos) begin
            // a checksum byte with bit 7 set never matches
            if ({1'b0, s_sum} != i_data_byte && s_ferr == sdfc_pkg::ST_OK) begin
                f_ferr = sdfc_pkg::ST_CHECKSUM;
            end
        end
    end

    // Frame verdict, ranked length overrun, header, command, end byte, checksum
    assign frame_end = (r_pos >= end_pos);
    always_comb begin
        if (r_pos > end_pos) begin
            f_status = sdfc_pkg::ST_LENGTH;
        end else if (f_ferr == sdfc_pkg::ST_HEADER || f_ferr == sdfc_pkg::ST_COMMAND) begin
            f_status = f_ferr;
        end else if (i_data_byte != sdfc_pkg::END_BYTE) begin
            f_status = sdfc_pkg::ST_END;
        end else if (f_ferr == sdfc_pkg::ST_CHECKSUM) begin
            f_status = sdfc_pkg::ST_CHECKSUM;
        end else begin
            f_status = sdfc_pkg::ST_OK;
        end
    end

    assign ok_after = r_all_ok && (f_status == sdfc_pkg::ST_OK);

    // Result word and next state
    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_ferr    = r_ferr;
        n_bank    = r_bank;
        n_prog    = r_prog;
        n_count   = r_count;
        n_all_ok  = r_all_ok;
        n_overrun = r_overrun;
        o_res_vld = 1'b0;
        o_res.status         = sdfc_pkg::ST_LENGTH;
        o_res.bank_number    = r_bank;
        o_res.program_number = r_prog;
        o_res.block_index    = r_count;
        o_res.buffer_done    = 1'b1;
        o_res.buffer_ok      = 1'b0;

        if (r_overrun) begin
            // trailing bytes after a single frame: swallow until the last mark
            o_res_vld = i_last_byte;
            if (i_last_byte) begin
                n_pos     = '0;
                n_count   = 8'd0;
                n_all_ok  = 1'b1;
                n_overrun = 1'b0;
            end
        end else begin
            n_sum  = f_sum;
            n_ferr = f_ferr;
            n_bank = f_bank;
            n_prog = f_prog;
            o_res.bank_number    = f_bank;
            o_res.program_number = f_prog;
            if (frame_end) begin
                o_res_vld          = 1'b1;
                o_res.status       = f_status;
                o_res.buffer_done  = i_last_byte;
                o_res.buffer_ok    = ok_after;
                n_pos    = '0;
                n_count  = (r_count == sdfc_pkg::COUNT_MAX) ? r_count : r_count + 8'd1;
                n_all_ok = ok_after;
                if (i_last_byte) begin
                    n_count  = 8'd0;
                    n_all_ok = 1'b1;
                end else if (!i_frame_mode) begin
                    n_overrun = 1'b1;
                end
            end else if (i_last_byte) begin
                // buffer ends mid-frame
                o_res_vld = 1'b1;
                n_pos     = '0;
                n_count   = 8'd0;
                n_all_ok  = 1'b1;
            end else begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_sum     <= 7'd0;
            r_ferr    <= sdfc_pkg::ST_OK;
            r_bank    <= 8'd0;
            r_prog    <= 8'd0;
            r_count   <= 8'd0;
            r_all_ok  <= 1'b1;
            r_overrun <= 1'b0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_ferr    <= n_ferr;
            r_bank    <= n_bank;
            r_prog    <= n_prog;
            r_count   <= n_count;
            r_all_ok  <= n_all_ok;
            r_overrun <= n_overrun;
        end
    end

endmodule

@@ rtl/core/sysex_dump_frame_checker_unit.sv @@
// Path: a word held in the input register is checked combinationally when it advances,
//   and any status word it closes is captured in the output register at that edge.
// Throughput: one byte word per cycle while the output is not back-pressured; a waiting
//   result holds the next word in the input register, so output back-pressure stalls input.
// Reset: synchronous, active low; clears frame state, frame_mode and the valid flags.
module sysex_dump_frame_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdfc_in_if.sink     i_in,
    sdfc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               frame_mode;
    logic               advance;
    logic               res_vld;
    sdfc_pkg::t_result  res;

    // Input register
    logic               r_in_vld, n_in_vld;
    logic [7:0]         r_in_byte;
    logic               r_in_last;

    // Output register
    logic               r_out_vld, n_out_vld;
    sdfc_pkg::t_result  r_out;

    sdfc_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_frame_mode (frame_mode)
    );

    // Word moves on when the output slot is free or being emptied
    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    always_comb begin
        n_in_vld = r_in_vld;
        if (i_in.valid && i_in.ready) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    sdfc_frame_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .i_frame_mode (frame_mode),
        .o_res_vld    (res_vld),
        .o_res        (res)
    );

    // Result register
    always_comb begin
        n_out_vld = r_out_vld;
        if (advance && res_vld) begin
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.status         = r_out.status;
    assign o_out.bank_number    = r_out.bank_number;
    assign o_out.program_number = r_out.program_number;
    assign o_out.block_index    = r_out.block_index;
    assign o_out.buffer_done    = r_out.buffer_done;
    assign o_out.buffer_ok      = r_out.buffer_ok;

`ifndef SYNTHESIS
    // a failed frame can never report a clean buffer
    a_fail_clears_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.status != sdfc_pkg::ST_OK) |-> !r_out.buffer_ok)
        else $error("failed frame reported with buffer_ok set");

    // a held input word is not lost or replaced while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_byte) && $stable(r_in_last))
        else $error("stalled input word changed");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.status <= sdfc_pkg::ST_LENGTH))
        else $error("undefined status code");
`endif

endmodule

@@ test/tb.sv @@
module tb;

    localparam int CYCLE_LIMIT    = 2000000;
    localparam int ITEMS_TARGET   = 1350;
    localparam int RESULTS_TARGET = 60;
    localparam int DRAIN_CYCLES   = 4;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_BYTES    = 250;
    localparam logic [2:0] FRAME_MODE_ADDR = 3'(4 * int'(sdfc_pkg::REG_FRAME_MODE));
    localparam logic [7:0] SYSEX_HDR [0:4] = '{8'hF0, 8'h00, 8'h20, 8'h33, 8'h01};

    // Predictor of the frame checker plus the queue of status words it owes
    class frame_status_board;
        bit                 dump_mode;
        int                 frame_pos;
        logic [6:0]         run_sum;
        sdfc_pkg::t_status  first_fault;
        logic [7:0]         held_bank;
        logic [7:0]         held_prog;
        logic [7:0]         frame_idx;
        bit                 all_good;
        bit                 swallowing;
        sdfc_pkg::t_result  expected_status[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            dump_mode    = 1'b0;
            run_sum      = '0;
            first_fault  = sdfc_pkg::ST_OK;
            held_bank    = '0;
            held_prog    = '0;
            mismatches   = 0;
            results_seen = 0;
            end_buffer();
        endfunction

        function void end_buffer();
            frame_pos  = 0;
            frame_idx  = '0;
            all_good   = 1'b1;
            swallowing = 1'b0;
        endfunction

        function void set_mode(bit m);
            dump_mode = m;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        function void push_status(sdfc_pkg::t_status st, bit done);
            sdfc_pkg::t_result w;
            w.status         = st;
            w.bank_number    = held_bank;
            w.program_number = held_prog;
            w.block_index    = frame_idx;
            w.buffer_done    = done;
            w.buffer_ok      = all_good;
            expected_status  = {expected_status, w};
        endfunction

        // One accepted byte word: advance the frame and queue any status it closes
        function void note_byte(logic [7:0] b, bit is_last);
            int                 flen;
            int                 p;
            sdfc_pkg::t_status  st;
            flen = dump_mode ? sdfc_pkg::BANK_LEN : sdfc_pkg::SINGLE_LEN;
            p    = frame_pos;

            // bytes after a finished single frame are dropped up to the last mark
            if (swallowing) begin
                if (!is_last) return;
                all_good = 1'b0;
                push_status(sdfc_pkg::ST_LENGTH, 1'b1);
                end_buffer();
                return;
            end

            if (p == 0) begin
                run_sum     = '0;
                first_fault = sdfc_pkg::ST_OK;
                held_bank   = '0;
                held_prog   = '0;
            end

            if (p < sdfc_pkg::HDR_LEN) begin
                if (b != SYSEX_HDR[p] && first_fault == sdfc_pkg::ST_OK)
                    first_fault = sdfc_pkg::ST_HEADER;
            end else if (p == 5) begin
                run_sum = run_sum + b[6:0];
            end else if (p == 6) begin
                if (b != sdfc_pkg::CMD_BYTE && first_fault == sdfc_pkg::ST_OK)
                    first_fault = sdfc_pkg::ST_COMMAND;
                run_sum = run_sum + sdfc_pkg::CMD_BYTE[6:0];
            end else if (p == 7) begin
                held_bank = b;
                run_sum   = run_sum + b[6:0];
            end else if (p == 8) begin
                held_prog = b;
                run_sum   = run_sum + b[6:0];
            end else if (p >= sdfc_pkg::PAY_START && p + 3 <= flen) begin
                run_sum = run_sum + b[6:0];
            end else if (p + 2 == flen) begin
                // bit 7 set on the checksum byte can never match
                if (b != {1'b0, run_sum} && first_fault == sdfc_pkg::ST_OK)
                    first_fault = sdfc_pkg::ST_CHECKSUM;
            end

            // frame end, or past it after a mode change
            if (p + 1 >= flen) begin
                if (p + 1 > flen)
                    st = sdfc_pkg::ST_LENGTH;
                else if (first_fault == sdfc_pkg::ST_HEADER ||
                         first_fault == sdfc_pkg::ST_COMMAND)
                    st = first_fault;
                else if (b != sdfc_pkg::END_BYTE)
                    st = sdfc_pkg::ST_END;
                else if (first_fault == sdfc_pkg::ST_CHECKSUM)
                    st = sdfc_pkg::ST_CHECKSUM;
                else
                    st = sdfc_pkg::ST_OK;
                if (st != sdfc_pkg::ST_OK) all_good = 1'b0;
                push_status(st, is_last);
                frame_pos = 0;
                if (frame_idx != sdfc_pkg::COUNT_MAX) frame_idx++;
                if (is_last)
                    end_buffer();
                else if (!dump_mode)
                    swallowing = 1'b1;
                return;
            end

            // buffer closed mid-frame
            if (is_last) begin
                all_good = 1'b0;
                push_status(sdfc_pkg::ST_LENGTH, 1'b1);
                end_buffer();
                return;
            end

            frame_pos = p + 1;
        endfunction

        function void check_status(sdfc_pkg::t_result got);
            sdfc_pkg::t_result want;
            results_seen++;
            if (expected_status.size() == 0) begin
                report($sformatf("unexpected word status=%0d bank=%02h prog=%02h block=%0d",
                                 got.status, got.bank_number, got.program_number,
                                 got.block_index));
                return;
            end
            want = expected_status.pop_front();
            if (got.status !== want.status || got.bank_number !== want.bank_number ||
                got.program_number !== want.program_number ||
                got.block_index !== want.block_index ||
                got.buffer_done !== want.buffer_done || got.buffer_ok !== want.buffer_ok)
                report($sformatf({"exp/act status %0d/%0d bank %02h/%02h prog %02h/%02h ",
                                  "block %0d/%0d done %0b/%0b ok %0b/%0b"},
                                 want.status, got.status, want.bank_number, got.bank_number,
                                 want.program_number, got.program_number,
                                 want.block_index, got.block_index,
                                 want.buffer_done, got.buffer_done,
                                 want.buffer_ok, got.buffer_ok));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sdfc_in_if  in_ch ();
    sdfc_out_if out_ch ();

    frame_status_board sb = new();

    logic [7:0] frame_q[$];
    int         bytes_sent = 0;
    int         cycle_count = 0;
    int         hold_len = 0;
    bit         burst = 1'b0;

    sysex_dump_frame_checker_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Status sink: random stalls, run-lengths of readiness, one long hold-off on request
    initial begin : status_sink
        int                 stall_left;
        int                 run_left;
        int                 r;
        sdfc_pkg::t_result  got;
        stall_left = 0;
        run_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.status         = sdfc_pkg::t_status'(out_ch.status);
                got.bank_number    = out_ch.bank_number;
                got.program_number = out_ch.program_number;
                got.block_index    = out_ch.block_index;
                got.buffer_done    = out_ch.buffer_done;
                got.buffer_ok      = out_ch.buffer_ok;
                sb.check_status(got);
            end
            if (hold_len > 0) begin
                stall_left = hold_len;
                run_left   = 0;
                hold_len   = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    run_left = $urandom_range(0, 30);
                    out_ch.ready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 2);
                    out_ch.ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(10, 40);
                    out_ch.ready <= 1'b0;
                end
            end
        end
    end

    // Gap before the next byte word: mostly none, a few long
    function automatic int sender_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(logic [7:0] b, bit is_last);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= is_last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_words(bit close_buf);
        int k;
        for (k = 0; k < frame_q.size(); k++)
            send_byte(frame_q[k], close_buf && (k == frame_q.size() - 1));
    endtask

    // Wait until every owed status word is back and the pipeline is empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write, then read back through a fresh setup phase
    task automatic write_mode(bit m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRAME_MODE_ADDR;
        pwdata  <= {31'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_mode(m);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== m) sb.report($sformatf("frame_mode read back %0b, wrote %0b",
                                                 prdata[0], m));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Well-formed frame with random content; now and then one or more faults
    function automatic void build_frame(int flen);
        logic [6:0] cks;
        int         k;
        int         faults;
        frame_q.delete();
        for (k = 0; k < sdfc_pkg::HDR_LEN; k++) frame_q = {frame_q, SYSEX_HDR[k]};
        frame_q = {frame_q, 8'($urandom_range(0, 255))};
        frame_q = {frame_q, sdfc_pkg::CMD_BYTE};
        frame_q = {frame_q, 8'($urandom_range(0, 255))};
        frame_q = {frame_q, 8'($urandom_range(0, 255))};
        for (k = sdfc_pkg::PAY_START; k < flen - 2; k++)
            frame_q = {frame_q, 8'($urandom_range(0, 255))};
        cks = '0;
        for (k = 5; k < flen - 2; k++) cks = cks + frame_q[k][6:0];
        frame_q = {frame_q, {1'b0, cks}};
        frame_q = {frame_q, sdfc_pkg::END_BYTE};
        if ($urandom_range(0, 99) < 50) begin
            faults = $urandom_range(1, 15);
            if (faults[0])
                frame_q[$urandom_range(0, sdfc_pkg::HDR_LEN - 1)] ^= 8'($urandom_range(1, 255));
            if (faults[1]) frame_q[6] ^= 8'($urandom_range(1, 255));
            if (faults[2]) frame_q[flen - 1] ^= 8'($urandom_range(1, 255));
            if (faults[3]) begin
                if ($urandom_range(0, 1))
                    frame_q[flen - 2] ^= 8'($urandom_range(1, 127));
                else
                    frame_q[flen - 2] |= 8'h80;
            end
        end
    endfunction

    // One buffer of a randomly chosen shape
    task automatic send_buffer(bit m, int pick);
        int flen;
        int nblk;
        int cut;
        int k;
        flen  = m ? sdfc_pkg::BANK_LEN : sdfc_pkg::SINGLE_LEN;
        burst = ($urandom_range(0, 3) == 0);
        if (pick < 30) begin
            // whole frames, last mark on the final end byte
            nblk = m ? $urandom_range(1, 3) : 1;
            for (k = 0; k < nblk; k++) begin
                build_frame(flen);
                send_words(k == nblk - 1);
            end
        end else if (pick < 42) begin
            // a frame followed by stray bytes
            build_frame(flen);
            send_words(1'b0);
            frame_q.delete();
            cut = $urandom_range(1, 6);
            for (k = 0; k < cut; k++) frame_q = {frame_q, 8'($urandom_range(0, 255))};
            send_words(1'b1);
        end else if (pick < 88) begin
            // short buffer: a frame prefix or plain noise
            cut = $urandom_range(1, 30);
            if ($urandom_range(0, 1)) begin
                build_frame(flen);
                frame_q = frame_q[0:cut - 1];
            end else begin
                frame_q.delete();
                for (k = 0; k < cut; k++) frame_q = {frame_q, 8'($urandom_range(0, 255))};
            end
            send_words(1'b1);
        end else begin
            // frame cut off somewhere past the bank and program bytes
            build_frame(flen);
            cut = $urandom_range(sdfc_pkg::PAY_START, flen - 1);
            frame_q = frame_q[0:cut - 1];
            send_words(1'b1);
        end
        burst = 1'b0;
    endtask

    initial begin : stimulus
        bit mode_now;
        bit open_frame;
        int phase_no;
        int phase_start;
        int k;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte buffers at both byte extremes, a header prefix holding
        // bank and program, a bad header cut short, then a bank-mode fragment
        write_mode(1'b0);
        frame_q = '{8'h00};
        send_words(1'b1);
        frame_q = '{8'hFF};
        send_words(1'b1);
        frame_q = '{8'hF0, 8'h00, 8'h20, 8'h33, 8'h01, 8'h7F, 8'h10, 8'hFF, 8'h80};
        send_words(1'b1);
        frame_q = '{8'hF1, 8'h00};
        send_words(1'b1);
        settle();
        write_mode(1'b1);
        frame_q = '{8'hF0, 8'h00, 8'h20, 8'h33, 8'h01, 8'h00, 8'h22, 8'h00, 8'h00, 8'h55};
        send_words(1'b1);

        // Random phases, each under one frame_mode setting
        mode_now   = 1'b0;
        open_frame = 1'b0;
        phase_no   = 0;
        while (bytes_sent < ITEMS_TARGET || sb.results_seen < RESULTS_TARGET) begin
            settle();
            if (open_frame || phase_no < 2)
                mode_now = ~mode_now;
            else
                mode_now = $urandom_range(0, 1);
            write_mode(mode_now);
            // a frame left open across the mode change is closed off first
            if (open_frame) begin
                frame_q.delete();
                for (k = $urandom_range(1, 5); k > 0; k--)
                    frame_q = {frame_q, 8'($urandom_range(0, 255))};
                send_words(1'b1);
                open_frame = 1'b0;
            end
            // long output hold-off while short buffers keep coming back to back
            if (phase_no == 0) begin
                hold_len = LONG_HOLD;
                for (k = 0; k < 40; k++) send_buffer(mode_now, 50);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_buffer(mode_now, $urandom_range(0, 99));
            if ($urandom_range(0, 99) < 35) begin
                build_frame(mode_now ? sdfc_pkg::BANK_LEN : sdfc_pkg::SINGLE_LEN);
                frame_q = frame_q[0:(mode_now ? $urandom_range(270, 520)
                                              : $urandom_range(1, 260)) - 1];
                send_words(1'b0);
                open_frame = 1'b1;
            end
            phase_no++;
        end
        if (open_frame) begin
            frame_q = '{8'($urandom_range(0, 255))};
            send_words(1'b1);
        end

        in_ch.valid <= 1'b0;
        while (sb.expected_status.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
